// ===== design/prpl_pkg.sv =====
// Package for the prefix/port rule lookup block.
// Holds the rule entry type, query type, sizing constants and codes.
// No dependencies.
package prpl_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int LEN_W   = 6;
    localparam int MAX_LEN = 32;

    // operation codes carried in the kind field
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    typedef struct packed {
        logic [31:0]      prefix;
        logic [LEN_W-1:0] len;
        logic [15:0]      port;
        logic [1:0]       action;
        logic [2:0]       protocol;
        logic [1:0]       direction;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic [31:0]      addr;
        logic [LEN_W-1:0] len;
        logic [15:0]      port;
    } query_t;

    // network mask for a length of 0 to 32
    function automatic logic [31:0] len_mask(input logic [LEN_W-1:0] len);
        logic [31:0] m;
        m = '0;
        for (int b = 0; b < 32; b++) begin
            if ((32 - b) <= int'(len)) begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// ===== design/prefix_port_rule_lookup.sv =====
// Longest-prefix firewall rule table built as a row of rule cells.
// Insert and clear: one response, registered from the response state.
// Remove: one compaction step per removed rule, then the response.
// Lookup: compare and select states, then one rule per cycle while the output
// is free. Input is ready again once the last result is registered.
// Synchronous active-low reset empties the table; stored entries keep data.
module prefix_port_rule_lookup (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [31:0] s_address,
    input  logic [5:0]  s_prefix_len,
    input  logic [15:0] s_port,
    input  logic [1:0]  s_rule_action,
    input  logic [2:0]  s_rule_protocol,
    input  logic [1:0]  s_rule_direction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_action,
    output logic [2:0]  m_out_protocol,
    output logic [1:0]  m_out_direction,
    output logic        m_matched,
    output logic        m_status,
    output logic        m_last
);

    localparam int N = prpl_pkg::ENTRIES;
    localparam int CW = prpl_pkg::CNT_W;
    localparam int LW = prpl_pkg::LEN_W;
    localparam int NL = prpl_pkg::MAX_LEN + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LKA  = 3'd1;
    localparam logic [2:0] ST_LKB  = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_REM  = 3'd4;
    localparam logic [2:0] ST_RESP = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              found_reg, found_next;
    logic              resp_status_reg, resp_status_next;
    logic              resp_match_reg;
    prpl_pkg::query_t  query_reg, query_next;
    logic [N-1:0]      hit_reg;
    logic [NL-1:0]     lenvec_reg;
    logic [N-1:0]      emit_reg, emit_next;

    logic              m_valid_reg;
    logic [1:0]        out_action_reg;
    logic [2:0]        out_protocol_reg;
    logic [1:0]        out_direction_reg;
    logic              out_matched_reg, out_status_reg, out_last_reg;

    prpl_pkg::entry_t  entries [N];
    prpl_pkg::entry_t  ins_data;
    logic [N-1:0]      hit, rm, vld, shv, wrv;
    logic              accept, out_free, full, ins_go, rem_step;
    logic [LW-1:0]     sat_len;
    logic [NL-1:0]     lenvec;
    logic [LW-1:0]     best;
    logic [N-1:0]      emit_sel, emit_one;
    prpl_pkg::entry_t  pick;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg >= CW'(N));
    assign sat_len  = (s_prefix_len > LW'(prpl_pkg::MAX_LEN)) ?
                      LW'(prpl_pkg::MAX_LEN) : s_prefix_len;
    assign ins_go   = accept && (s_kind == prpl_pkg::KIND_INSERT) && !full;
    assign rem_step = (state_reg == ST_REM) && (rm != '0);

    always_comb begin
        ins_data.prefix    = s_address & prpl_pkg::len_mask(sat_len);
        ins_data.len       = sat_len;
        ins_data.port      = s_port;
        ins_data.action    = s_rule_action;
        ins_data.protocol  = s_rule_protocol;
        ins_data.direction = s_rule_direction;
    end

    // row of cells; shift enable ripples up from the lowest removed rule
    for (genvar i = 0; i < N; i++) begin : g_cell
        assign vld[i] = (CW'(i) < count_reg);
        assign wrv[i] = ins_go && (count_reg == CW'(i));
        if (i == 0) begin : g_first
            assign shv[i] = rm[i];
        end else begin : g_rest
            assign shv[i] = shv[i-1] | rm[i];
        end
        prpl_cell u_cell (
            .aclk     (aclk),
            .wr_en    (wrv[i]),
            .wr_data  (ins_data),
            .shift_en (rem_step && shv[i]),
            .nb_data  (entries[(i + 1 < N) ? i + 1 : i]),
            .valid    (vld[i]),
            .query    (query_reg),
            .entry    (entries[i]),
            .hit      (hit[i]),
            .rm       (rm[i])
        );
    end

    // lengths present among hits
    always_comb begin
        lenvec = '0;
        for (int i = 0; i < N; i++) begin
            if (hit[i]) begin
                lenvec[entries[i].len] = 1'b1;
            end
        end
    end

    // longest length present
    always_comb begin
        best = '0;
        for (int l = 0; l < NL; l++) begin
            if (lenvec_reg[l]) begin
                best = LW'(l);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            emit_sel[i] = hit_reg[i] && (entries[i].len == best);
        end
    end

    // lowest pending rule, in insertion order
    assign emit_one = emit_reg & (~emit_reg + N'(1));
    always_comb begin
        pick = '0;
        for (int i = 0; i < N; i++) begin
            if (emit_one[i]) begin
                pick = pick | entries[i];
            end
        end
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        found_next       = found_reg;
        resp_status_next = resp_status_reg;
        query_next       = query_reg;
        emit_next        = emit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_kind)
                        prpl_pkg::KIND_INSERT: begin
                            resp_status_next = full;
                            if (!full) begin
                                count_next = count_reg + CW'(1);
                            end
                            state_next = ST_RESP;
                        end
                        prpl_pkg::KIND_CLEAR: begin
                            count_next       = '0;
                            resp_status_next = 1'b0;
                            state_next       = ST_RESP;
                        end
                        prpl_pkg::KIND_REMOVE: begin
                            query_next.addr = s_address & prpl_pkg::len_mask(sat_len);
                            query_next.len  = sat_len;
                            query_next.port = s_port;
                            found_next      = 1'b0;
                            state_next      = ST_REM;
                        end
                        default: begin
                            query_next.addr = s_address;
                            query_next.len  = sat_len;
                            query_next.port = s_port;
                            state_next      = ST_LKA;
                        end
                    endcase
                end
            end
            ST_LKA: begin
                state_next = ST_LKB;
            end
            ST_LKB: begin
                if (lenvec_reg == '0) begin
                    resp_status_next = 1'b0;
                    state_next       = ST_RESP;
                end else begin
                    emit_next  = emit_sel;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit_next = emit_reg & ~emit_one;
                    if ((emit_reg & ~emit_one) == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REM: begin
                if (rm != '0) begin
                    count_next = count_reg - CW'(1);
                    found_next = 1'b1;
                end else begin
                    resp_status_next = !found_reg;
                    state_next       = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            found_reg <= found_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        resp_status_reg <= resp_status_next;
        query_reg       <= query_next;
        emit_reg        <= emit_next;
        if (state_reg == ST_LKA) begin
            hit_reg    <= hit;
            lenvec_reg <= lenvec;
        end
        if (state_reg == ST_IDLE) begin
            resp_match_reg <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_EMIT || state_reg == ST_RESP) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            out_action_reg    <= pick.action;
            out_protocol_reg  <= pick.protocol;
            out_direction_reg <= pick.direction;
            out_matched_reg   <= 1'b1;
            out_status_reg    <= 1'b0;
            out_last_reg      <= ((emit_reg & ~emit_one) == '0);
        end else if (state_reg == ST_RESP && out_free) begin
            out_action_reg    <= '0;
            out_protocol_reg  <= '0;
            out_direction_reg <= '0;
            out_matched_reg   <= resp_match_reg;
            out_status_reg    <= resp_status_reg;
            out_last_reg      <= 1'b1;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_action    = out_action_reg;
    assign m_out_protocol  = out_protocol_reg;
    assign m_out_direction = out_direction_reg;
    assign m_matched       = out_matched_reg;
    assign m_status        = out_status_reg;
    assign m_last          = out_last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(N))
        else $error("rule count beyond table size");

    a_emit_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (emit_reg != '0))
        else $error("emit state with no pending rule");

    a_rem_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REM) |=> (count_reg <= $past(count_reg)))
        else $error("remove grew the table");

    a_idle_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE))
        else $error("input accepted while busy");
`endif

endmodule

// ===== design/prpl_cell.sv =====
// One rule cell: stores one entry, loads from the insert bus or from its
// upper neighbor, and compares itself against the broadcast query.
// Depends on prpl_pkg.
module prpl_cell (
    input  logic             aclk,
    input  logic             wr_en,
    input  prpl_pkg::entry_t wr_data,
    input  logic             shift_en,
    input  prpl_pkg::entry_t nb_data,
    input  logic             valid,
    input  prpl_pkg::query_t query,
    output prpl_pkg::entry_t entry,
    output logic             hit,
    output logic             rm
);

    prpl_pkg::entry_t entry_reg;

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg <= wr_data;
        end else if (shift_en) begin
            entry_reg <= nb_data;
        end
    end

    assign entry = entry_reg;

    // lookup: port equal and address inside the stored prefix
    assign hit = valid && (entry_reg.port == query.port) &&
                 ((query.addr & prpl_pkg::len_mask(entry_reg.len)) == entry_reg.prefix);

    // remove: exact prefix and length (query address already masked)
    assign rm = valid && (entry_reg.len == query.len) && (entry_reg.prefix == query.addr);

endmodule
